// ===== rtl/ucrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_pkg
// Shared types, codes and descriptor tables of the endpoint-0 request
// responder.
// ----------------------------------------------------------------------------
package ucrr_pkg;

  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 16;

  // event codes
  localparam logic [1:0] OP_BUS_RESET = 2'd0;
  localparam logic [1:0] OP_SETUP     = 2'd1;
  localparam logic [1:0] OP_IN_DONE   = 2'd2;
  localparam logic [1:0] OP_OUT_DONE  = 2'd3;

  // reply kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ZLP    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UID_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UID_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UID_HIGH = 2'd2;

  // setup decoding
  localparam logic [4:0] RECIP_DEVICE    = 5'h00;
  localparam logic [4:0] RECIP_INTERFACE = 5'h01;
  localparam logic [1:0] TYPE_STANDARD   = 2'd0;
  localparam logic [1:0] TYPE_CLASS      = 2'd1;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] DT_DEVICE       = 8'h01;
  localparam logic [7:0] DT_CONFIG       = 8'h02;
  localparam logic [7:0] DT_STRING       = 8'h03;
  localparam logic [7:0] DT_QUALIFIER    = 8'h06;
  localparam logic [7:0] DT_HID_REPORT   = 8'h22;
  localparam logic [7:0] STR_LANGUAGE    = 8'd0;
  localparam logic [7:0] STR_MAKER       = 8'd1;
  localparam logic [7:0] STR_PRODUCT     = 8'd2;
  localparam logic [7:0] STR_SERIAL      = 8'd3;

  // byte sources
  localparam logic [3:0] SRC_DEVICE  = 4'd0;
  localparam logic [3:0] SRC_CONFIG  = 4'd1;
  localparam logic [3:0] SRC_QUAL    = 4'd2;
  localparam logic [3:0] SRC_LANG    = 4'd3;
  localparam logic [3:0] SRC_REPORT  = 4'd4;
  localparam logic [3:0] SRC_MAKER   = 4'd5;
  localparam logic [3:0] SRC_PRODUCT = 4'd6;
  localparam logic [3:0] SRC_SERIAL  = 4'd7;
  localparam logic [3:0] SRC_ZLP     = 4'd8;
  localparam logic [3:0] SRC_STATUS  = 4'd9;

  localparam logic [5:0] LEN_ONE     = 6'd1;
  localparam logic [5:0] LEN_DEVICE  = 6'd18;
  localparam logic [5:0] LEN_CONFIG  = 6'd41;
  localparam logic [5:0] LEN_QUAL    = 6'd10;
  localparam logic [5:0] LEN_LANG    = 6'd4;
  localparam logic [5:0] LEN_REPORT  = 6'd3;
  localparam logic [5:0] LEN_MAKER   = 6'd38;
  localparam logic [5:0] LEN_PRODUCT = 6'd50;
  localparam logic [5:0] LEN_SERIAL  = 6'd26;

  localparam logic [7:0] HDR_MAKER   = 8'h26;
  localparam logic [7:0] HDR_PRODUCT = 8'h32;
  localparam logic [7:0] HDR_SERIAL  = 8'h1A;

  localparam logic [7:0] TAB_DEVICE [0:17] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h83, 8'h04,
    8'h5A, 8'h57, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01
  };

  localparam logic [7:0] TAB_CONFIG [0:40] = '{
    8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h03, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h02, 8'h00, 8'h05,
    8'h07, 8'h05, 8'h01, 8'h03, 8'h02, 8'h00, 8'h05
  };

  localparam logic [7:0] TAB_QUAL [0:9] = '{
    8'h0A, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00
  };

  localparam logic [7:0] TAB_LANG [0:3] = '{8'h04, 8'h03, 8'h09, 8'h04};

  localparam logic [7:0] TAB_REPORT [0:3] = '{8'hA1, 8'h01, 8'hC0, 8'h00};

  localparam logic [7:0] TXT_MAKER [0:31] = '{
    8'h53, 8'h54, 8'h4D, 8'h69, 8'h63, 8'h72, 8'h6F, 8'h65, 8'h6C,
    8'h65, 8'h63, 8'h74, 8'h72, 8'h6F, 8'h6E, 8'h69, 8'h63, 8'h73,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] TXT_PRODUCT [0:31] = '{
    8'h53, 8'h54, 8'h4D, 8'h33, 8'h32, 8'h20, 8'h4C, 8'h65, 8'h61, 8'h72,
    8'h6E, 8'h69, 8'h6E, 8'h67, 8'h20, 8'h49, 8'h6E, 8'h74, 8'h65, 8'h72,
    8'h66, 8'h61, 8'h63, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00
  };

  typedef struct packed {
    logic accept;
    logic emit;
  } ucrr_cmd_t;

  typedef struct packed {
    logic has_reply;
    logic at_last;
    logic out_free;
  } ucrr_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = {4'h3, nib};
    end else begin
      ch = {4'h0, nib} + 8'h37;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/ucrr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_ctrl
// Controller: takes one event at a time and steps the datapath through the
// reply words it causes.
// ----------------------------------------------------------------------------
module ucrr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ucrr_pkg::ucrr_sts_t sts,
  output ucrr_pkg::ucrr_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.has_reply) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ucrr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucrr_dp
// Datapath: setup decode, address and configuration state, identifier
// registers, descriptor byte generation and the output register.
// ----------------------------------------------------------------------------
module ucrr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ucrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucrr_pkg::CFG_W-1:0]          cfg_data,
  input  logic [1:0]                          in_opcode,
  input  logic [ucrr_pkg::IN_DATA_W-1:0]      in_data,
  input  ucrr_pkg::ucrr_cmd_t                 cmd,
  output ucrr_pkg::ucrr_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ucrr_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [1:0]                          out_kind,
  output logic                                out_last
);

  logic [31:0] uid_low;
  logic [31:0] uid_mid;
  logic [31:0] uid_high;
  logic [6:0]  pending_address;
  logic [6:0]  current_address;
  logic        config_done;
  logic [3:0]  src;
  logic [5:0]  len;
  logic [5:0]  idx;

  logic [7:0]  rtype;
  logic [7:0]  code;
  logic [15:0] value;
  logic [15:0] length;
  logic [4:0]  recip;
  logic [1:0]  rkind;
  logic [7:0]  dtype;
  logic        std_device;
  logic [5:0]  config_clip;
  logic [5:0]  report_clip;
  logic        dec_hit;
  logic [3:0]  dec_src;
  logic [5:0]  dec_len;

  logic [31:0] uid_sum;
  logic        blank;
  logic [47:0] hex_word;
  logic [5:0]  j;
  logic [3:0]  digit_rev;
  logic [3:0]  nib;
  logic [7:0]  gen_byte;
  logic [1:0]  gen_kind;

  assign rtype      = in_data[7:0];
  assign code       = in_data[15:8];
  assign value      = in_data[31:16];
  assign length     = in_data[63:48];
  assign recip      = rtype[4:0];
  assign rkind      = rtype[6:5];
  assign dtype      = value[15:8];
  assign std_device = (recip == ucrr_pkg::RECIP_DEVICE) && (rkind == ucrr_pkg::TYPE_STANDARD);
  assign config_clip = (length < 16'(ucrr_pkg::LEN_CONFIG)) ? length[5:0] : ucrr_pkg::LEN_CONFIG;
  assign report_clip = (length < 16'(ucrr_pkg::LEN_REPORT)) ? length[5:0] : ucrr_pkg::LEN_REPORT;

  always_comb begin
    dec_hit = 1'b0;
    dec_src = ucrr_pkg::SRC_ZLP;
    dec_len = ucrr_pkg::LEN_ONE;
    case (in_opcode)
      ucrr_pkg::OP_BUS_RESET: dec_hit = 1'b0;
      ucrr_pkg::OP_SETUP: begin
        if (std_device) begin
          case (code)
            ucrr_pkg::REQ_SET_ADDRESS: dec_hit = 1'b1;
            ucrr_pkg::REQ_SET_CONFIG:  dec_hit = 1'b1;
            ucrr_pkg::REQ_GET_DESC: begin
              case (dtype)
                ucrr_pkg::DT_DEVICE: begin
                  dec_hit = 1'b1;
                  dec_src = ucrr_pkg::SRC_DEVICE;
                  dec_len = ucrr_pkg::LEN_DEVICE;
                end
                ucrr_pkg::DT_CONFIG: begin
                  dec_hit = 1'b1;
                  if (config_clip != 6'd0) begin
                    dec_src = ucrr_pkg::SRC_CONFIG;
                    dec_len = config_clip;
                  end
                end
                ucrr_pkg::DT_STRING: begin
                  dec_hit = 1'b1;
                  case (value[7:0])
                    ucrr_pkg::STR_LANGUAGE: begin
                      dec_src = ucrr_pkg::SRC_LANG;
                      dec_len = ucrr_pkg::LEN_LANG;
                    end
                    ucrr_pkg::STR_MAKER: begin
                      dec_src = ucrr_pkg::SRC_MAKER;
                      dec_len = ucrr_pkg::LEN_MAKER;
                    end
                    ucrr_pkg::STR_PRODUCT: begin
                      dec_src = ucrr_pkg::SRC_PRODUCT;
                      dec_len = ucrr_pkg::LEN_PRODUCT;
                    end
                    ucrr_pkg::STR_SERIAL: begin
                      dec_src = ucrr_pkg::SRC_SERIAL;
                      dec_len = ucrr_pkg::LEN_SERIAL;
                    end
                    default: dec_hit = 1'b0;
                  endcase
                end
                ucrr_pkg::DT_QUALIFIER: begin
                  dec_hit = 1'b1;
                  dec_src = ucrr_pkg::SRC_QUAL;
                  dec_len = ucrr_pkg::LEN_QUAL;
                end
                default: dec_hit = 1'b0;
              endcase
            end
            default: dec_hit = 1'b0;
          endcase
        end else if (recip == ucrr_pkg::RECIP_INTERFACE) begin
          if (rkind == ucrr_pkg::TYPE_STANDARD && code == ucrr_pkg::REQ_GET_DESC &&
              dtype == ucrr_pkg::DT_HID_REPORT) begin
            dec_hit = 1'b1;
            if (report_clip != 6'd0) begin
              dec_src = ucrr_pkg::SRC_REPORT;
              dec_len = report_clip;
            end
          end else if (rkind == ucrr_pkg::TYPE_CLASS) begin
            dec_hit = 1'b1;
          end
        end
      end
      default: begin
        dec_hit = 1'b1;
        dec_src = ucrr_pkg::SRC_STATUS;
      end
    endcase
  end

  assign sts.has_reply = dec_hit;
  assign sts.at_last   = (idx == len - 6'd1);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      uid_low  <= '0;
      uid_mid  <= '0;
      uid_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ucrr_pkg::CFG_UID_LOW:  uid_low  <= cfg_data;
        ucrr_pkg::CFG_UID_MID:  uid_mid  <= cfg_data;
        ucrr_pkg::CFG_UID_HIGH: uid_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_address <= '0;
      current_address <= '0;
      config_done     <= 1'b0;
    end else if (cmd.accept) begin
      case (in_opcode)
        ucrr_pkg::OP_BUS_RESET: begin
          pending_address <= '0;
          current_address <= '0;
          config_done     <= 1'b0;
        end
        ucrr_pkg::OP_SETUP: begin
          if (std_device && code == ucrr_pkg::REQ_SET_ADDRESS) begin
            pending_address <= value[6:0];
          end
          if (std_device && code == ucrr_pkg::REQ_SET_CONFIG) begin
            config_done <= 1'b1;
          end
        end
        ucrr_pkg::OP_IN_DONE: begin
          if (pending_address != 7'd0) begin
            current_address <= pending_address;
            pending_address <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src <= dec_src;
      len <= dec_len;
      idx <= '0;
    end else if (cmd.emit) begin
      idx <= idx + 6'd1;
    end
  end

  // byte generation
  assign uid_sum   = uid_low + uid_high;
  assign blank     = (uid_sum == 32'd0);
  assign hex_word  = {uid_sum, uid_mid[31:16]};
  assign j         = idx - 6'd2;
  assign digit_rev = 4'd11 - j[4:1];
  assign nib       = hex_word[{digit_rev, 2'b00} +: 4];

  always_comb begin
    gen_kind = ucrr_pkg::KIND_DATA;
    gen_byte = 8'h00;
    case (src)
      ucrr_pkg::SRC_DEVICE: gen_byte = ucrr_pkg::TAB_DEVICE[idx[4:0]];
      ucrr_pkg::SRC_CONFIG: gen_byte = ucrr_pkg::TAB_CONFIG[idx];
      ucrr_pkg::SRC_QUAL:   gen_byte = ucrr_pkg::TAB_QUAL[idx[3:0]];
      ucrr_pkg::SRC_LANG:   gen_byte = ucrr_pkg::TAB_LANG[idx[1:0]];
      ucrr_pkg::SRC_REPORT: gen_byte = ucrr_pkg::TAB_REPORT[idx[1:0]];
      ucrr_pkg::SRC_MAKER: begin
        if (idx == 6'd0) begin
          gen_byte = ucrr_pkg::HDR_MAKER;
        end else if (idx == 6'd1) begin
          gen_byte = ucrr_pkg::DT_STRING;
        end else if (!j[0]) begin
          gen_byte = ucrr_pkg::TXT_MAKER[j[5:1]];
        end
      end
      ucrr_pkg::SRC_PRODUCT: begin
        if (idx == 6'd0) begin
          gen_byte = ucrr_pkg::HDR_PRODUCT;
        end else if (idx == 6'd1) begin
          gen_byte = ucrr_pkg::DT_STRING;
        end else if (!j[0]) begin
          gen_byte = ucrr_pkg::TXT_PRODUCT[j[5:1]];
        end
      end
      ucrr_pkg::SRC_SERIAL: begin
        if (idx == 6'd0) begin
          gen_byte = ucrr_pkg::HDR_SERIAL;
        end else if (idx == 6'd1) begin
          gen_byte = ucrr_pkg::DT_STRING;
        end else if (!j[0] && !blank) begin
          gen_byte = ucrr_pkg::hex_char(nib);
        end
      end
      ucrr_pkg::SRC_ZLP:    gen_kind = ucrr_pkg::KIND_ZLP;
      ucrr_pkg::SRC_STATUS: gen_kind = ucrr_pkg::KIND_STATUS;
      default: gen_kind = ucrr_pkg::KIND_DATA;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {config_done, current_address, gen_byte};
      out_kind <= gen_kind;
      out_last <= sts.at_last;
    end
  end

endmodule

// ===== rtl/usb_control_request_responder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_control_request_responder_top
// Endpoint-0 standard and class request responder with descriptor streaming.
// ----------------------------------------------------------------------------
// The s_axis channel takes one endpoint-0 event per word; s_axis_tuser holds
// the event code. The m_axis channel returns reply words, one per descriptor
// byte or one zero-length / status word, with tlast on the final word of the
// event. The cfg port writes the three unique-identifier registers used for
// the serial string; write only while no event is in flight.
// One event is handled at a time: the event is taken, then its n reply words
// (n up to 50, the product string) leave one per cycle from the output
// register while m_axis_tready does not hold them. Events with no reply (bus
// reset, unknown requests) leave the block ready for the next event. The rate
// is set by the single byte generator that walks the descriptor index. After
// the event is taken, the first reply word enters the output register once
// that register is free. A new event is taken while the last reply word
// still waits in the output register. When m_axis_tready is low the output
// register holds its word and the generator waits. Synchronous reset clears
// the address, configured flag, identifier registers and all handshake state.
// ----------------------------------------------------------------------------
module usb_control_request_responder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ucrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ucrr_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // setup_type, request_code, request_value, request_index, request_length
  input  logic [ucrr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // data_byte, device_address, configured
  output logic [ucrr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // reply_kind
  output logic [1:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  ucrr_pkg::ucrr_cmd_t cmd;
  ucrr_pkg::ucrr_sts_t sts;

  ucrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ucrr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_opcode (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // the word after the final reply is loaded, a new event can be taken
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.at_last) |=> s_axis_tready)
    else $error("input not ready after final reply word");

  // transfer-done events always produce a status word, so the block is busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == ucrr_pkg::OP_IN_DONE || s_axis_tuser == ucrr_pkg::OP_OUT_DONE))
    |=> !s_axis_tready)
    else $error("transfer-done event produced no reply");

  // bus reset produces no reply and leaves the block idle
  a_bus_reset_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ucrr_pkg::OP_BUS_RESET)
    |=> s_axis_tready)
    else $error("bus reset left the block busy");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the endpoint-0 control request responder. A queue
// of endpoint-0 events (directed descriptor, address, configuration and
// status cases, then mostly well-formed random request traffic) feeds a
// clocked driver. Each accepted event is run through a local behavioral
// predictor that tracks address, configured flag and the unique-ID
// registers, and the reply words it yields are compared in order, field by
// field, by a clocked monitor. The identifier registers are reloaded between
// phases while the block is idle; both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import ucrr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } ep0_event_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] addr;
    logic       cfgd;
  } reply_t;

  localparam logic [7:0] DESC_DEVICE [0:17] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h83, 8'h04,
    8'h5A, 8'h57, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03, 8'h01
  };
  localparam logic [7:0] DESC_CONFIG [0:40] = '{
    8'h09, 8'h02, 8'h29, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00,
    8'h09, 8'h21, 8'h11, 8'h01, 8'h00, 8'h01, 8'h22, 8'h03, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h03, 8'h02, 8'h00, 8'h05,
    8'h07, 8'h05, 8'h01, 8'h03, 8'h02, 8'h00, 8'h05
  };
  localparam logic [7:0] DESC_QUAL [0:9] = '{
    8'h0A, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h01, 8'h00
  };
  localparam logic [7:0] DESC_LANG [0:3] = '{8'h04, 8'h03, 8'h09, 8'h04};
  localparam logic [7:0] DESC_REPORT [0:2] = '{8'hA1, 8'h01, 8'hC0};
  localparam logic [7:0] TEXT_MAKER [0:17] = '{
    8'h53, 8'h54, 8'h4D, 8'h69, 8'h63, 8'h72, 8'h6F, 8'h65, 8'h6C,
    8'h65, 8'h63, 8'h74, 8'h72, 8'h6F, 8'h6E, 8'h69, 8'h63, 8'h73
  };
  localparam logic [7:0] TEXT_PRODUCT [0:23] = '{
    8'h53, 8'h54, 8'h4D, 8'h33, 8'h32, 8'h20, 8'h4C, 8'h65, 8'h61, 8'h72,
    8'h6E, 8'h69, 8'h6E, 8'h67, 8'h20, 8'h49, 8'h6E, 8'h74, 8'h65, 8'h72,
    8'h66, 8'h61, 8'h63, 8'h65
  };
  localparam int unsigned MAKER_LEN = 18;
  localparam int unsigned PRODUCT_LEN = 24;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  usb_control_request_responder_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] uid_low = '0;
  logic [31:0] uid_mid = '0;
  logic [31:0] uid_high = '0;
  logic [6:0]  pend_addr = '0;
  logic [6:0]  cur_addr = '0;
  logic        cfg_flag = 1'b0;

  ep0_event_t  event_q [$];
  reply_t      reply_q [$];
  ep0_event_t  cur_ev;
  logic        ev_loaded = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned events_sent = 0;
  int unsigned words_checked = 0;
  int unsigned id_settings = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic reply_t reply_word(input logic [1:0] kind, input logic [7:0] data);
    reply_t r;
    r = '0;
    r.kind = kind;
    r.data = data;
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  // expected reply words of one accepted event, appended to reply_q
  task automatic predict_replies(input ep0_event_t ev);
    reply_t      step [$];
    int unsigned n;
    logic [4:0]  recip;
    logic [1:0]  rkind;
    logic [7:0]  dtype;
    logic [31:0] sum;
    logic        blank;
    recip = ev.rtype[4:0];
    rkind = ev.rtype[6:5];
    dtype = ev.value[15:8];
    case (ev.op)
      OP_BUS_RESET: begin
        pend_addr = '0;
        cur_addr = '0;
        cfg_flag = 1'b0;
      end
      OP_IN_DONE: begin
        if (pend_addr != '0) begin
          cur_addr = pend_addr;
          pend_addr = '0;
        end
        step.push_back(reply_word(KIND_STATUS, 8'h00));
      end
      OP_OUT_DONE: step.push_back(reply_word(KIND_STATUS, 8'h00));
      default: begin
        if (recip == RECIP_DEVICE && rkind == TYPE_STANDARD) begin
          case (ev.code)
            REQ_SET_ADDRESS: begin
              pend_addr = ev.value[6:0];
              step.push_back(reply_word(KIND_ZLP, 8'h00));
            end
            REQ_SET_CONFIG: begin
              cfg_flag = 1'b1;
              step.push_back(reply_word(KIND_ZLP, 8'h00));
            end
            REQ_GET_DESC: begin
              case (dtype)
                DT_DEVICE: begin
                  for (int i = 0; i < 18; i++) step.push_back(reply_word(KIND_DATA, DESC_DEVICE[i]));
                end
                DT_CONFIG: begin
                  n = (ev.length < 16'd41) ? 32'(ev.length) : 32'd41;
                  if (n == 0) step.push_back(reply_word(KIND_ZLP, 8'h00));
                  for (int i = 0; i < n; i++) step.push_back(reply_word(KIND_DATA, DESC_CONFIG[i]));
                end
                DT_QUALIFIER: begin
                  for (int i = 0; i < 10; i++) step.push_back(reply_word(KIND_DATA, DESC_QUAL[i]));
                end
                DT_STRING: begin
                  case (ev.value[7:0])
                    STR_LANGUAGE: begin
                      for (int i = 0; i < 4; i++) step.push_back(reply_word(KIND_DATA, DESC_LANG[i]));
                    end
                    STR_MAKER: begin
                      step.push_back(reply_word(KIND_DATA, 8'(2 * MAKER_LEN + 2)));
                      step.push_back(reply_word(KIND_DATA, 8'h03));
                      for (int i = 0; i < MAKER_LEN; i++) begin
                        step.push_back(reply_word(KIND_DATA, TEXT_MAKER[i]));
                        step.push_back(reply_word(KIND_DATA, 8'h00));
                      end
                    end
                    STR_PRODUCT: begin
                      step.push_back(reply_word(KIND_DATA, 8'(2 * PRODUCT_LEN + 2)));
                      step.push_back(reply_word(KIND_DATA, 8'h03));
                      for (int i = 0; i < PRODUCT_LEN; i++) begin
                        step.push_back(reply_word(KIND_DATA, TEXT_PRODUCT[i]));
                        step.push_back(reply_word(KIND_DATA, 8'h00));
                      end
                    end
                    STR_SERIAL: begin
                      sum = uid_low + uid_high;
                      blank = (sum == '0);
                      step.push_back(reply_word(KIND_DATA, 8'h1A));
                      step.push_back(reply_word(KIND_DATA, 8'h03));
                      // eight digits of the sum, then the top four of the middle word
                      for (int i = 0; i < 12; i++) begin
                        if (i < 8) begin
                          step.push_back(reply_word(KIND_DATA,
                            blank ? 8'h00 : hex_digit(sum[31 - 4 * i -: 4])));
                        end else begin
                          step.push_back(reply_word(KIND_DATA,
                            blank ? 8'h00 : hex_digit(uid_mid[31 - 4 * (i - 8) -: 4])));
                        end
                        step.push_back(reply_word(KIND_DATA, 8'h00));
                      end
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end else if (recip == RECIP_INTERFACE) begin
          if (rkind == TYPE_STANDARD && ev.code == REQ_GET_DESC && dtype == DT_HID_REPORT) begin
            n = (ev.length < 16'd3) ? 32'(ev.length) : 32'd3;
            if (n == 0) step.push_back(reply_word(KIND_ZLP, 8'h00));
            for (int i = 0; i < n; i++) step.push_back(reply_word(KIND_DATA, DESC_REPORT[i]));
          end else if (rkind == TYPE_CLASS) begin
            step.push_back(reply_word(KIND_ZLP, 8'h00));
          end
        end
      end
    endcase
    for (int i = 0; i < step.size(); i++) begin
      step[i].last = (i == step.size() - 1);
      step[i].addr = cur_addr;
      step[i].cfgd = cfg_flag;
      reply_q.push_back(step[i]);
    end
  endtask

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch in %s: got 0x%0h, want 0x%0h (word %0d, t=%0t)",
             field, got, want, words_checked, $realtime);
    fail_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_replies(cur_ev);
        events_sent++;
        ev_loaded = 1'b0;
        if ($urandom_range(0, 99) < src_gap_pct) gap_left = $urandom_range(1, 14);
      end
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (event_q.size() != 0) begin
        cur_ev = event_q.pop_front();
        ev_loaded = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cur_ev.length, cur_ev.index, cur_ev.value, cur_ev.code, cur_ev.rtype};
        s_axis_tuser <= cur_ev.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          flag_mismatch("unexpected word", 32'({m_axis_tuser, m_axis_tdata}), 32'd0);
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tuser != want.kind)
            flag_mismatch("reply_kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata[7:0] != want.data)
            flag_mismatch("data_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
          if (m_axis_tlast != want.last)
            flag_mismatch("last_byte", 32'(m_axis_tlast), 32'(want.last));
          if (m_axis_tdata[14:8] != want.addr)
            flag_mismatch("device_address", 32'(m_axis_tdata[14:8]), 32'(want.addr));
          if (m_axis_tdata[15] != want.cfgd)
            flag_mismatch("configured", 32'(m_axis_tdata[15]), 32'(want.cfgd));
        end
        words_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_UID_LOW:  uid_low = val;
      CFG_UID_MID:  uid_mid = val;
      CFG_UID_HIGH: uid_high = val;
      default: ;
    endcase
  endtask

  task automatic load_ids(input logic [31:0] low, input logic [31:0] mid,
                          input logic [31:0] high);
    write_reg(CFG_UID_LOW, low);
    write_reg(CFG_UID_MID, mid);
    write_reg(CFG_UID_HIGH, high);
    @(posedge clk);
    cfg_we <= 1'b0;
    id_settings++;
  endtask

  task automatic wait_idle();
    while (event_q.size() != 0 || ev_loaded || reply_q.size() != 0) @(posedge clk);
    // an event with no reply may still be in the block
    repeat (4) @(posedge clk);
  endtask

  task automatic post_event(input logic [1:0] op, input logic [7:0] rtype,
                            input logic [7:0] code, input logic [15:0] value,
                            input logic [15:0] length);
    ep0_event_t ev;
    ev.op = op;
    ev.rtype = rtype;
    ev.code = code;
    ev.value = value;
    ev.index = 16'($urandom);
    ev.length = length;
    event_q.push_back(ev);
  endtask

  // mostly well-formed requests with random content, some noise
  function automatic ep0_event_t random_event();
    ep0_event_t  ev;
    int unsigned pick;
    logic        dir;
    ev.op = OP_SETUP;
    ev.rtype = 8'($urandom);
    ev.code = 8'($urandom);
    ev.value = 16'($urandom);
    ev.index = 16'($urandom);
    ev.length = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 45)) : 16'($urandom);
    dir = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      ev.op = OP_BUS_RESET;
    end else if (pick < 18) begin
      ev.op = OP_IN_DONE;
    end else if (pick < 24) begin
      ev.op = OP_OUT_DONE;
    end else if (pick < 34) begin
      ev.rtype = {dir, TYPE_STANDARD, RECIP_DEVICE};
      ev.code = REQ_SET_ADDRESS;
    end else if (pick < 40) begin
      ev.rtype = {dir, TYPE_STANDARD, RECIP_DEVICE};
      ev.code = REQ_SET_CONFIG;
    end else if (pick < 74) begin
      ev.rtype = {dir, TYPE_STANDARD, RECIP_DEVICE};
      ev.code = REQ_GET_DESC;
      case ($urandom_range(0, 5))
        0: ev.value[15:8] = DT_DEVICE;
        1: ev.value[15:8] = DT_CONFIG;
        2, 3: begin
          ev.value[15:8] = DT_STRING;
          ev.value[7:0] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        end
        4: ev.value[15:8] = DT_QUALIFIER;
        default: ;
      endcase
    end else if (pick < 82) begin
      ev.rtype = {dir, TYPE_STANDARD, RECIP_INTERFACE};
      ev.code = REQ_GET_DESC;
      ev.value[15:8] = DT_HID_REPORT;
      if ($urandom_range(0, 9) < 7) ev.length = 16'($urandom_range(0, 5));
    end else if (pick < 88) begin
      ev.rtype = {dir, TYPE_CLASS, RECIP_INTERFACE};
    end
    return ev;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned gap_pct,
                            input int unsigned stall_pct);
    src_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) event_q.push_back(random_event());
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all-zero identifier: blank serial
    load_ids(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    src_gap_pct = 30;
    sink_stall_pct = 8;
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, STR_SERIAL}, 16'h00FF);
    wait_idle();

    load_ids(32'h89AB_CDEF, 32'h01EF_5A5A, 32'h0000_0000);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0040);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'h0000);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'h0009);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_CONFIG, 8'h00}, 16'hFFFF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_QUALIFIER, 8'h00}, 16'h000A);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, STR_LANGUAGE}, 16'h00FF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, STR_MAKER}, 16'h00FF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, STR_PRODUCT}, 16'h00FF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, STR_SERIAL}, 16'h00FF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, {DT_STRING, 8'h04}, 16'h00FF);
    post_event(OP_SETUP, 8'h80, REQ_GET_DESC, 16'h0700, 16'h00FF);
    post_event(OP_SETUP, 8'h81, REQ_GET_DESC, {DT_HID_REPORT, 8'h00}, 16'h0000);
    post_event(OP_SETUP, 8'h81, REQ_GET_DESC, {DT_HID_REPORT, 8'h00}, 16'h0002);
    post_event(OP_SETUP, 8'h81, REQ_GET_DESC, {DT_HID_REPORT, 8'h00}, 16'hFFFF);
    post_event(OP_SETUP, 8'h21, 8'h0A, 16'h0000, 16'h0000);
    post_event(OP_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFF7F, 16'h0000);
    post_event(OP_OUT_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    post_event(OP_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    post_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    post_event(OP_SETUP, 8'h00, REQ_SET_CONFIG, 16'h0000, 16'h0000);
    post_event(OP_SETUP, 8'hC0, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0040);
    post_event(OP_SETUP, 8'h82, REQ_GET_DESC, {DT_DEVICE, 8'h00}, 16'h0040);
    post_event(OP_SETUP, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    post_event(OP_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    post_event(OP_SETUP, 8'h00, REQ_SET_ADDRESS, 16'h0000, 16'h0000);
    post_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000);
    wait_idle();

    // sum wraps to 0xFFFFFFFE
    load_ids(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(60, 25, 6);
    // nonzero words whose sum wraps to zero
    load_ids(32'h0000_0001, 32'hA5C3_0000, 32'hFFFF_FFFF);
    run_random(50, 40, 12);
    load_ids($urandom, $urandom, $urandom);
    run_random(60, 15, 4);
    load_ids($urandom, $urandom, $urandom);
    run_random(55, 30, 10);
    // closing stretch without any idling
    load_ids($urandom, $urandom, $urandom);
    run_random(60, 0, 0);

    repeat (16) @(posedge clk);
    $display("%0d events sent, %0d reply words checked, %0d identifier settings",
             events_sent, words_checked, id_settings);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
